[design/snl_pkg.sv]
// Shared types and constants for the number literal scanner.
// Used by snl_csr, snl_scan and number_literal_scanner; depends on nothing.
package snl_pkg;

   localparam int MAX_LEN_DEFAULT = 4095;
   localparam int LEN_W           = 12;
   localparam int VALUE_W         = 64;
   localparam int MAG_W           = 64;
   localparam int PROD_W          = MAG_W + 4;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;
   localparam int RSP_DATA_W      = 80;

   localparam logic [LEN_W-1:0] LEN_MAX = 12'd4095;
   localparam logic [MAG_W-1:0] TWO63   = 64'h8000_0000_0000_0000;

   // register index, taken from paddr[2]
   localparam logic REG_ALLOW_DOUBLE = 1'b0;

   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;
   localparam logic [7:0] CHAR_LOW_E = 8'h65;
   localparam logic [7:0] CHAR_UP_E  = 8'h45;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_BEGIN,
      PH_MINUS,
      PH_PLUS,
      PH_INT,
      PH_ZERO,
      PH_DOT,
      PH_FRAC,
      PH_EXP,
      PH_EXPSIGN,
      PH_EXPDIG
   } phase_type;

   typedef enum logic [1:0] {
      ST_INTEGER = 2'd0,
      ST_REAL    = 2'd1,
      ST_ERROR   = 2'd2
   } status_type;

   typedef struct packed {
      logic       start_req;
      logic [7:0] char_byte;
      logic       last_byte;
   } scan_item_type;

   typedef struct packed {
      status_type                 status;
      logic signed [VALUE_W-1:0]  integer_value;
      logic [LEN_W-1:0]           consumed_length;
   } scan_result_type;

endpackage

[design/snl_csr.sv]
// APB-style configuration register for the number literal scanner.
// Holds allow_double; depends on snl_pkg.
module snl_csr
   import snl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output logic                  allow_double
);

   logic allow_double_ff;
   logic allow_double_in;
   logic hit;

   assign hit        = (csr_paddr[2] == REG_ALLOW_DOUBLE);
   assign csr_pready = 1'b1;

   always_comb begin
      allow_double_in = allow_double_ff;
      if (csr_psel && csr_penable && csr_pwrite && hit) begin
         allow_double_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_double_ff <= 1'b1;
      end else begin
         allow_double_ff <= allow_double_in;
      end
   end

   assign csr_prdata   = hit ? {{(CSR_DATA_W-1){1'b0}}, allow_double_ff} : '0;
   assign allow_double = allow_double_ff;

endmodule

[design/snl_scan.sv]
// Scanner state and per-byte update: phase, sign, magnitude, byte count.
// Produces at most one result per byte; depends on snl_pkg.
module snl_scan
   import snl_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            step_valid,
   input  scan_item_type   item,
   input  logic            allow_double,
   output logic            res_valid,
   output scan_result_type result
);

   localparam int CountW = $clog2(MAX_LEN + 1);
   localparam int CmpW   = (CountW > LEN_W) ? CountW : LEN_W;

   phase_type          phase_ff, phase_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic               ovf_ff, ovf_in;
   logic               minus_ff, minus_in;
   logic               noint_ff, noint_in;
   logic [CountW-1:0]  cnt_ff, cnt_in;

   phase_type          ph_b, ph_acc;
   logic [MAG_W-1:0]   mag_b;
   logic               ovf_b, minus_b, noint_b;
   logic [CountW-1:0]  cnt_b;
   logic               acc, int_start, add_dig, is_dig, is_e;
   logic [3:0]         dig;
   logic [PROD_W-1:0]  prod;
   logic               dig_ovf;
   logic               finish;
   logic [7:0]         c;

   always_comb begin : next_state
      c         = item.char_byte;
      is_dig    = (c >= CHAR_0) && (c <= CHAR_9);
      is_e      = (c == CHAR_LOW_E) || (c == CHAR_UP_E);
      dig       = c[3:0];
      // a start byte clears the number in progress
      ph_b      = item.start_req ? PH_BEGIN : phase_ff;
      mag_b     = item.start_req ? '0 : mag_ff;
      ovf_b     = item.start_req ? 1'b0 : ovf_ff;
      minus_b   = item.start_req ? 1'b0 : minus_ff;
      noint_b   = item.start_req ? 1'b0 : noint_ff;
      cnt_b     = item.start_req ? '0 : cnt_ff;
      prod      = ({4'b0, mag_b} << 3) + ({4'b0, mag_b} << 1) + PROD_W'(dig);
      dig_ovf   = prod > {4'b0, TWO63};
      ph_acc    = ph_b;
      mag_in    = mag_b;
      ovf_in    = ovf_b;
      minus_in  = minus_b;
      noint_in  = noint_b;
      acc       = 1'b0;
      int_start = 1'b0;
      add_dig   = 1'b0;
      case (ph_b)
         PH_BEGIN: begin
            if (c == CHAR_MINUS) begin
               minus_in = 1'b1;
               ph_acc   = PH_MINUS;
               acc      = 1'b1;
            end else if (c == CHAR_PLUS) begin
               ph_acc = PH_PLUS;
               acc    = 1'b1;
            end else begin
               int_start = 1'b1;
            end
         end
         PH_MINUS: begin
            if (c == CHAR_PLUS) begin
               ph_acc = PH_PLUS;
               acc    = 1'b1;
            end else begin
               int_start = 1'b1;
            end
         end
         PH_PLUS: int_start = 1'b1;
         PH_INT, PH_ZERO: begin
            if (is_dig && ph_b == PH_INT) begin
               add_dig = 1'b1;
               acc     = 1'b1;
            end else if (allow_double && c == CHAR_DOT) begin
               noint_in = 1'b1;
               ph_acc   = PH_DOT;
               acc      = 1'b1;
            end else if (allow_double && is_e) begin
               noint_in = 1'b1;
               ph_acc   = PH_EXP;
               acc      = 1'b1;
            end
         end
         PH_DOT: begin
            if (is_dig) begin
               ph_acc = PH_FRAC;
               acc    = 1'b1;
            end
         end
         PH_FRAC: begin
            if (is_dig) begin
               acc = 1'b1;
            end else if (is_e) begin
               ph_acc = PH_EXP;
               acc    = 1'b1;
            end
         end
         PH_EXP: begin
            if (c == CHAR_PLUS || c == CHAR_MINUS) begin
               ph_acc = PH_EXPSIGN;
               acc    = 1'b1;
            end else if (is_dig) begin
               ph_acc = PH_EXPDIG;
               acc    = 1'b1;
            end
         end
         PH_EXPSIGN, PH_EXPDIG: begin
            if (is_dig) begin
               ph_acc = PH_EXPDIG;
               acc    = 1'b1;
            end
         end
         default: acc = 1'b0;
      endcase
      if (int_start) begin
         if (c == CHAR_0) begin
            ph_acc = PH_ZERO;
            acc    = 1'b1;
         end else if (is_dig) begin
            ph_acc  = PH_INT;
            add_dig = 1'b1;
            acc     = 1'b1;
         end
      end
      // freeze the magnitude once it passes two to the sixty-third
      if (add_dig && !ovf_b) begin
         if (dig_ovf) begin
            ovf_in   = 1'b1;
            noint_in = 1'b1;
         end else begin
            mag_in = prod[MAG_W-1:0];
         end
      end
      cnt_in = cnt_b;
      if (acc && cnt_b != CountW'(MAX_LEN)) begin
         cnt_in = cnt_b + CountW'(1);
      end
      finish   = step_valid && (ph_b != PH_IDLE) && (!acc || item.last_byte);
      phase_in = finish ? PH_IDLE : ph_acc;
   end

   logic [CmpW-1:0]  cnt_ext;
   logic [LEN_W-1:0] len_sat;
   logic             can_end;

   always_comb begin : result_out
      cnt_ext   = CmpW'(cnt_in);
      len_sat   = (cnt_ext > CmpW'(LEN_MAX)) ? LEN_MAX : cnt_ext[LEN_W-1:0];
      can_end   = (ph_acc == PH_INT) || (ph_acc == PH_ZERO) ||
                  (ph_acc == PH_FRAC) || (ph_acc == PH_EXPDIG);
      res_valid = finish;
      result.status          = ST_ERROR;
      result.integer_value   = '0;
      result.consumed_length = '0;
      if (!can_end) begin
         result.status = ST_ERROR;
      end else if (noint_in) begin
         if (allow_double) begin
            result.status          = ST_REAL;
            result.consumed_length = len_sat;
         end
      end else if (minus_in) begin
         result.status          = ST_INTEGER;
         result.integer_value   = -$signed(mag_in);
         result.consumed_length = len_sat;
      end else if (mag_in != TWO63) begin
         result.status          = ST_INTEGER;
         result.integer_value   = $signed(mag_in);
         result.consumed_length = len_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         mag_ff   <= '0;
         ovf_ff   <= 1'b0;
         minus_ff <= 1'b0;
         noint_ff <= 1'b0;
         cnt_ff   <= '0;
      end else if (step_valid) begin
         phase_ff <= phase_in;
         mag_ff   <= mag_in;
         ovf_ff   <= ovf_in;
         minus_ff <= minus_in;
         noint_ff <= noint_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[design/number_literal_scanner.sv]
// Top level of the number literal scanner: input register, scanner, result register.
// Depends on snl_pkg, snl_csr and snl_scan.
//
//   channel  direction  contents
//   req      in         tdata char_byte, tuser start_req, tlast last_byte
//   rsp      out        tdata integer_value, consumed_length; tuser status
//   csr      in/out     APB, allow_double at byte address 0
//
// One byte is taken per cycle while the scanner is not stalled; rsp_tvalid rises
// once the ending byte has passed the input register, where the state update
// works on it, and the result register, which takes the result when the scanner steps.
// Reset clears the phase, counters and valid flags.
// A stalled result holds the scanner, and one more byte waits in the input
// register before req_tready drops.
module number_literal_scanner
   import snl_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] char_byte
   input  logic [0:0]            req_tuser,   // [0] start_req
   input  logic                  req_tlast,   // last_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [63:0] integer_value, [75:64] consumed_length
   output logic [1:0]            rsp_tuser,   // [1:0] status
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic            allow_double;
   logic            in_valid_ff, in_valid_in;
   scan_item_type   in_item_ff;
   logic            out_valid_ff, out_valid_in;
   scan_result_type out_result_ff;
   logic            step;
   logic            res_valid;
   scan_result_type result;

   snl_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .allow_double (allow_double)
   );

   // advance the scanner only when the result register has room
   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   snl_scan #(
      .MAX_LEN (MAX_LEN)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .step_valid   (step),
      .item         (in_item_ff),
      .allow_double (allow_double),
      .res_valid    (res_valid),
      .result       (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
      end
      out_valid_in = out_valid_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (step && res_valid) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.start_req <= req_tuser[0];
         in_item_ff.char_byte <= req_tdata;
         in_item_ff.last_byte <= req_tlast;
      end
      if (step && res_valid) begin
         out_result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_result_ff.status;
   assign rsp_tdata  = {4'b0, out_result_ff.consumed_length, out_result_ff.integer_value};

endmodule
